FILE: hdl/ilp_pkg.sv
package ilp_pkg;

  localparam int WIDTH_DEF = 32;
  localparam int VALUE_W   = 32;

  typedef enum logic [1:0] {
    PH_FIRST       = 2'd0,
    PH_AFTER_MINUS = 2'd1,
    PH_AFTER_ZERO  = 2'd2,
    PH_DIGITS      = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2,
    RX_OCT = 2'd3
  } radix_t;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [3:0] TEN      = 4'd10;

  typedef struct packed {
    logic       ok;
    logic [3:0] digit;
  } ilp_digit_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               error;
  } ilp_result_t;

endpackage

FILE: hdl/ilp_digit_dec.sv
module ilp_digit_dec
  import ilp_pkg::*;
(
  input  logic [7:0] ch,
  input  radix_t     radix,
  output ilp_digit_t dig
);

  logic [7:0] raw;
  logic       is_alnum;

  always_comb begin
    raw      = 8'd0;
    is_alnum = 1'b1;
    case (ch) inside
      [CH_0:CH_9]:             raw = ch - CH_0;
      [CH_LA:CH_LA + 8'd5]:    raw = ch - CH_LA + 8'(TEN);
      [CH_UA:CH_UA + 8'd5]:    raw = ch - CH_UA + 8'(TEN);
      default:                 is_alnum = 1'b0;
    endcase
  end

  always_comb begin
    dig.digit = raw[3:0];
    case (radix)
      RX_HEX:  dig.ok = is_alnum;
      RX_BIN:  dig.ok = is_alnum && (raw[3:0] < 4'd2);
      RX_OCT:  dig.ok = is_alnum && (raw[3:0] < 4'd8);
      default: dig.ok = is_alnum && (raw[3:0] < TEN);
    endcase
  end

endmodule

FILE: hdl/ilp_parse_core.sv
module ilp_parse_core
  import ilp_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic [7:0]  ch,
  input  logic        last,
  output ilp_result_t result
);

  phase_t             phase, phase_next;
  radix_t             radix_sel, radix_sel_next;
  logic               negative, negative_next;
  logic [WIDTH-1:0]   accum, accum_next;
  logic               bad, bad_next;

  radix_t             eff_radix;
  ilp_digit_t         dig;
  logic               do_take;
  logic [WIDTH-1:0]   acc_upd;
  logic [WIDTH-1:0]   signed_acc;
  logic               bad_final;
  logic [VALUE_W-1:0] value_ext;

  // leading characters always parse as decimal
  assign eff_radix = (phase == PH_FIRST || phase == PH_AFTER_MINUS) ? RX_DEC : radix_sel;

  ilp_digit_dec u_dec (
    .ch    (ch),
    .radix (eff_radix),
    .dig   (dig)
  );

  always_comb begin
    case (eff_radix)
      RX_HEX:  acc_upd = (accum << 4) | WIDTH'(dig.digit);
      RX_BIN:  acc_upd = (accum << 1) | WIDTH'(dig.digit);
      RX_OCT:  acc_upd = (accum << 3) | WIDTH'(dig.digit);
      default: acc_upd = (accum << 3) + (accum << 1) + WIDTH'(dig.digit);
    endcase
  end

  always_comb begin
    phase_next     = phase;
    radix_sel_next = radix_sel;
    negative_next  = negative;
    do_take        = 1'b0;
    case (phase)
      PH_FIRST: begin
        if (ch == CH_MINUS) begin
          negative_next = 1'b1;
          phase_next    = PH_AFTER_MINUS;
        end else if (ch == CH_0) begin
          radix_sel_next = RX_OCT;
          phase_next     = PH_AFTER_ZERO;
        end else begin
          radix_sel_next = RX_DEC;
          phase_next     = PH_DIGITS;
          do_take        = 1'b1;
        end
      end
      PH_AFTER_MINUS: begin
        if (ch == CH_0) begin
          radix_sel_next = RX_OCT;
          phase_next     = PH_AFTER_ZERO;
        end else begin
          radix_sel_next = RX_DEC;
          phase_next     = PH_DIGITS;
          do_take        = 1'b1;
        end
      end
      PH_AFTER_ZERO: begin
        phase_next = PH_DIGITS;
        if (ch == CH_LX || ch == CH_UX) begin
          radix_sel_next = RX_HEX;
        end else if (ch == CH_LB || ch == CH_UB) begin
          radix_sel_next = RX_BIN;
        end else begin
          do_take = 1'b1;
        end
      end
      default: begin
        do_take = 1'b1;
      end
    endcase

    accum_next = accum;
    bad_next   = bad;
    if (do_take && !bad) begin
      if (dig.ok) begin
        accum_next = acc_upd;
      end else begin
        bad_next = 1'b1;
      end
    end
  end

  assign bad_final  = bad_next || (phase_next == PH_AFTER_MINUS);
  assign signed_acc = negative_next ? ({WIDTH{1'b0}} - accum_next) : accum_next;

  generate
    if (WIDTH >= VALUE_W) begin : g_cut
      assign value_ext = signed_acc[VALUE_W-1:0];
    end else begin : g_sext
      assign value_ext = {{(VALUE_W-WIDTH){signed_acc[WIDTH-1]}}, signed_acc};
    end
  endgenerate

  assign result.value = bad_final ? '0 : value_ext;
  assign result.error = bad_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      radix_sel <= RX_DEC;
      negative  <= 1'b0;
      accum     <= '0;
      bad       <= 1'b0;
    end else if (adv) begin
      if (last) begin
        phase     <= PH_FIRST;
        radix_sel <= RX_DEC;
        negative  <= 1'b0;
        accum     <= '0;
        bad       <= 1'b0;
      end else begin
        phase     <= phase_next;
        radix_sel <= radix_sel_next;
        negative  <= negative_next;
        accum     <= accum_next;
        bad       <= bad_next;
      end
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (adv && last) |=> (phase == PH_FIRST && !bad && !negative && accum == '0))
    else $error("parser state not cleared after final character");

  a_first_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FIRST) |-> (!negative && !bad && accum == '0))
    else $error("stale state at literal start");

  a_bad_sticky: assert property (@(posedge clk) disable iff (rst)
    (bad && !(adv && last)) |=> bad)
    else $error("error flag dropped mid literal");

endmodule

FILE: hdl/ilp_out_reg.sv
module ilp_out_reg
  import ilp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  ilp_result_t        result,
  input  logic               out_stall,
  output logic               ready,
  output logic               out_valid,
  output logic [VALUE_W-1:0] value,
  output logic               error
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      value <= result.value;
      error <= result.error;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (value == '0))
    else $error("error result carries nonzero value");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (load && !ready) |-> 1'b0)
    else $error("result offered while output register blocked");

endmodule

FILE: hdl/integer_literal_parser.sv
// The final character's transaction passes the input register, then the parse logic
// into the result register. Throughput: one character per cycle while in_stall is
// low; the accumulate (shift or times ten plus digit) and the negate of the final
// value sit between the input and result registers.
// Reset (rst, synchronous): drops both registered valids and returns the parser
// to the start of a literal, decimal, positive, zero accumulator, no error.
module integer_literal_parser
  import ilp_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                ch,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] value,
  output logic                      error
);

  logic        s1_valid;
  logic [7:0]  s1_ch;
  logic        s1_last;
  logic        s1_adv;
  logic        out_ready;
  ilp_result_t result;
  logic [VALUE_W-1:0] value_u;

  // non-final characters never need the output register
  assign s1_adv   = s1_valid && (!s1_last || out_ready);
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_ch   <= ch;
      s1_last <= last;
    end
  end

  ilp_parse_core #(
    .WIDTH (WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .adv    (s1_adv),
    .ch     (s1_ch),
    .last   (s1_last),
    .result (result)
  );

  ilp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_adv && s1_last),
    .result    (result),
    .out_stall (out_stall),
    .ready     (out_ready),
    .out_valid (out_valid),
    .value     (value_u),
    .error     (error)
  );

  assign value = signed'(value_u);

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_last && !out_ready))
    else $error("input stalled without a blocked final character");

endmodule

FILE: verif/integer_literal_parser_test.sv
`timescale 1ns / 1ps

module integer_literal_parser_test;
  import ilp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_CHARS = 1050;
  localparam logic [4:0] NO_DIGIT = 5'h1F;

  typedef struct {
    logic [7:0]  c;
    logic        l;
    logic        typed;
    logic [31:0] v;
    logic        e;
  } stim_row_t;

  typedef struct {
    logic [31:0] value;
    logic        error;
  } literal_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [7:0]                ch = '0;
  logic                      last = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] value;
  logic                      error;

  // expectation typed into the directed table, travels with the transaction
  logic        typed_valid = 1'b0;
  logic [31:0] typed_value = '0;
  logic        typed_error = 1'b0;

  // parser state as predicted
  phase_t      lit_phase = PH_FIRST;
  radix_t      lit_radix = RX_DEC;
  logic        lit_neg   = 1'b0;
  logic [31:0] lit_accum = '0;
  logic        lit_bad   = 1'b0;

  literal_result_t pending_results[$];
  logic [7:0]      lit_chars[$];

  bit idle_on = 1'b0;
  int chars_sent = 0;
  int literal_count = 0;
  int results_checked = 0;
  int error_results = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  string extreme_lits[6] = '{"2147483647", "-2147483648", "0xFFFFFFFF", "-0x80000000",
                             "4294967296", "037777777777"};

  stim_row_t dir_rows[25] = '{
    '{CH_MINUS, 1'b1, 1'b1, 32'd0, 1'b1},        // lone minus
    '{CH_0, 1'b1, 1'b1, 32'd0, 1'b0},            // lone zero
    '{CH_0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CH_LX, 1'b1, 1'b1, 32'd0, 1'b0},           // hex prefix, no digits
    '{CH_0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CH_UB, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CH_0 + 8'd1, 1'b1, 1'b0, 32'd0, 1'b0},
    '{CH_MINUS, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CH_0, 1'b1, 1'b1, 32'd0, 1'b0},            // minus zero
    '{CH_0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CH_LX, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CH_UA + 8'd5, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CH_LA + 8'd5, 1'b1, 1'b0, 32'd0, 1'b0},
    '{CH_0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CH_0 + 8'd7, 1'b1, 1'b0, 32'd0, 1'b0},
    '{CH_0 + 8'd9, 1'b1, 1'b0, 32'd0, 1'b0},
    '{CH_0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CH_UX, 1'b1, 1'b1, 32'd0, 1'b0},           // upper hex prefix, no digits
    '{CH_0 + 8'd1, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'h00, 1'b1, 1'b1, 32'd0, 1'b1},           // NUL is no digit
    '{CH_MINUS, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CH_MINUS, 1'b1, 1'b1, 32'd0, 1'b1},        // second minus
    '{8'hFF, 1'b1, 1'b1, 32'd0, 1'b1},
    '{CH_0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CH_0 + 8'd8, 1'b1, 1'b1, 32'd0, 1'b1}      // 8 is not octal
  };

  integer_literal_parser dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ch       (ch),
    .last     (last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value    (value),
    .error    (error)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void add_digit(input logic [7:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if (lit_bad) return;
    if (c >= CH_0 && c <= CH_9) d = 5'(c - CH_0);
    else if (c >= CH_LA && c <= CH_LA + 8'd5) d = 5'(c - CH_LA + 8'd10);
    else if (c >= CH_UA && c <= CH_UA + 8'd5) d = 5'(c - CH_UA + 8'd10);
    case (lit_radix)
      RX_BIN: if (d > 5'd1) d = NO_DIGIT;
      RX_OCT: if (d > 5'd7) d = NO_DIGIT;
      RX_DEC: if (d > 5'd9) d = NO_DIGIT;
      default: ;
    endcase
    if (d == NO_DIGIT) begin
      lit_bad = 1'b1;
      return;
    end
    case (lit_radix)
      RX_HEX: lit_accum = {lit_accum[27:0], d[3:0]};
      RX_BIN: lit_accum = {lit_accum[30:0], d[0]};
      RX_OCT: lit_accum = {lit_accum[28:0], d[2:0]};
      default: lit_accum = lit_accum * TEN + d;
    endcase
  endfunction

  function automatic void start_digits(input logic [7:0] c);
    if (c == CH_0) begin
      lit_radix = RX_OCT;
      lit_phase = PH_AFTER_ZERO;
    end else begin
      lit_radix = RX_DEC;
      lit_phase = PH_DIGITS;
      add_digit(c);
    end
  endfunction

  // advances the predicted parser by one character; returns 1 when a result is due
  function automatic bit parse_char(input logic [7:0] c, input logic l,
                                    output logic [31:0] v, output logic e);
    case (lit_phase)
      PH_FIRST: begin
        if (c == CH_MINUS) begin
          lit_neg = 1'b1;
          lit_phase = PH_AFTER_MINUS;
        end else begin
          start_digits(c);
        end
      end
      PH_AFTER_MINUS: start_digits(c);
      PH_AFTER_ZERO: begin
        lit_phase = PH_DIGITS;
        if (c == CH_LX || c == CH_UX) lit_radix = RX_HEX;
        else if (c == CH_LB || c == CH_UB) lit_radix = RX_BIN;
        else add_digit(c);
      end
      default: add_digit(c);
    endcase
    v = '0;
    e = 1'b0;
    if (!l) return 1'b0;
    if (lit_phase == PH_AFTER_MINUS) lit_bad = 1'b1;
    e = lit_bad;
    if (!lit_bad) v = lit_neg ? -lit_accum : lit_accum;
    lit_phase = PH_FIRST;
    lit_radix = RX_DEC;
    lit_neg   = 1'b0;
    lit_accum = '0;
    lit_bad   = 1'b0;
    return 1'b1;
  endfunction

  // check results first, then predict from the input transaction of the same edge
  always @(posedge clk) begin
    literal_result_t want;
    logic [31:0] pv;
    logic pe;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result value %h error %b", $time, value, error);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (error) error_results++;
          if (value !== want.value) begin
            mismatch_count++;
            $display("%0t: value expected %h, got %h", $time, want.value, value);
          end
          if (error !== want.error) begin
            mismatch_count++;
            $display("%0t: error expected %b, got %b", $time, want.error, error);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (parse_char(ch, last, pv, pe)) begin
          if (typed_valid) pending_results.push_back('{typed_value, typed_error});
          else pending_results.push_back('{pv, pe});
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_results.size());
    $display("[integer_literal_parser] ERROR");
    $finish;
  end

  task automatic drive_char(input logic [7:0] c, input logic l, input logic tv,
                            input logic [31:0] t_v, input logic t_e);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    ch          <= c;
    last        <= l;
    typed_valid <= tv;
    typed_value <= t_v;
    typed_error <= t_e;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk);
  endtask

  initial begin
    radix_t base;
    int ndig;
    int dmax;
    int d;
    bit all_max;
    bit mid_pause_done;
    string s;
    mid_pause_done = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_on = 1'b1;
    foreach (dir_rows[i])
      drive_char(dir_rows[i].c, dir_rows[i].l, dir_rows[i].typed, dir_rows[i].v, dir_rows[i].e);
    literal_count += 13;
    drain_results();

    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      // quiet stretch in the middle, and none at all near the end
      idle_on = (chars_sent < 350) || (chars_sent >= 500 && chars_sent < 900);
      lit_chars.delete();
      case ($urandom_range(0, 19))
        0: begin
          s = extreme_lits[$urandom_range(0, 5)];
          for (int k = 0; k < s.len(); k++) lit_chars.push_back(s[k]);
        end
        1, 2, 3, 4: begin
          repeat ($urandom_range(1, 5)) lit_chars.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          if ($urandom_range(0, 2) == 0) lit_chars.push_back(CH_MINUS);
          base = radix_t'($urandom_range(0, 3));
          case (base)
            RX_HEX: begin
              lit_chars.push_back(CH_0);
              lit_chars.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
              dmax = 15;
              ndig = $urandom_range(0, 10);
            end
            RX_BIN: begin
              lit_chars.push_back(CH_0);
              lit_chars.push_back($urandom_range(0, 1) ? CH_LB : CH_UB);
              dmax = 1;
              ndig = $urandom_range(0, 3) == 0 ? $urandom_range(0, 34) : $urandom_range(0, 6);
            end
            RX_OCT: begin
              lit_chars.push_back(CH_0);
              dmax = 7;
              ndig = $urandom_range(0, 12);
            end
            default: begin
              dmax = 9;
              ndig = $urandom_range(1, 12);
            end
          endcase
          all_max = ($urandom_range(0, 9) == 0);
          for (int k = 0; k < ndig; k++) begin
            d = all_max ? dmax : $urandom_range(0, dmax);
            if (base == RX_DEC && k == 0 && d == 0) d = $urandom_range(1, 9);
            if (d < 10) lit_chars.push_back(CH_0 + 8'(d));
            else lit_chars.push_back(($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 10));
          end
          // broken literal: one character replaced by anything
          if ($urandom_range(0, 7) == 0)
            lit_chars[$urandom_range(0, lit_chars.size() - 1)] = 8'($urandom_range(0, 255));
        end
      endcase
      foreach (lit_chars[k])
        drive_char(lit_chars[k], k == lit_chars.size() - 1, 1'b0, '0, 1'b0);
      literal_count++;
      if (!mid_pause_done && chars_sent >= 600) begin
        drain_results();
        mid_pause_done = 1'b1;
      end
    end

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk);
    $display("Parsed %0d literals: directed corner cases plus random decimal, hex, octal,",
             literal_count);
    $display("binary, signed, broken and noise input; %0d results checked, %0d flagged bad.",
             results_checked, error_results);
    if (mismatch_count == 0) begin
      $display("[integer_literal_parser] OK");
    end else begin
      $display("[integer_literal_parser] ERROR");
    end
    $finish;
  end

endmodule
